// ----- src/lpps_pkg.sv -----
// Package for the linear-probe pointer set: sizes, slot codes, request codes and the hash.
// Depends on nothing; every other file of the block imports it.
package lpps_pkg;

  // Table geometry. Two banks of CAPACITY slots share one memory.
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned ADDR_W   = IDX_W + 1;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned KEY_W    = 64;

  localparam logic [CNT_W-1:0] HALF_CAP    = CNT_W'(CAPACITY / 2);
  localparam logic [CNT_W-1:0] QUARTER_CAP = CNT_W'(CAPACITY / 4);

  localparam logic [KEY_W-1:0] HASH_MULT  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KEY_W-1:0] SLOT_EMPTY = 64'd0;
  localparam logic [KEY_W-1:0] SLOT_TOMB  = 64'd1;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_FULL    = 2'd1,
    STS_INVALID = 2'd2
  } status_e;

  // Only the low index bits of the 64-bit product are kept, so a narrow
  // multiply of the low bits gives the same home slot.
  function automatic logic [IDX_W-1:0] hash_idx(logic [KEY_W-1:0] k);
    logic [KEY_W-1:0]   s;
    logic [2*IDX_W-1:0] prod;
    s    = k >> 4;
    prod = s[IDX_W-1:0] * HASH_MULT[IDX_W-1:0];
    return prod[IDX_W-1:0];
  endfunction

endpackage

// ----- src/lpps_req_if.sv -----
// Request channel of the linear-probe pointer set: valid/ready plus action and key.
// Depends on lpps_pkg for the key width.
interface lpps_req_if
  import lpps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [KEY_W-1:0] key;

  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

// ----- src/lpps_rsp_if.sv -----
// Response channel of the linear-probe pointer set: valid/ready plus the result fields.
// Depends on lpps_pkg for the count width.
interface lpps_rsp_if
  import lpps_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             was_present;
  logic [1:0]       status;
  logic [CNT_W-1:0] live_count;
  logic             rebuilt;

  modport source (output valid, was_present, status, live_count, rebuilt, input ready);
  modport sink   (input valid, was_present, status, live_count, rebuilt, output ready);
endinterface

// ----- src/linear_probe_pointer_set.sv -----
// Top level of the linear-probe pointer set: control sequencer and the slot memory.
// Depends on lpps_pkg, lpps_req_if and lpps_rsp_if.
//
// Usage: requests (action, key) enter on req_i, one response per request leaves on
// rsp_o. Each channel moves a transfer when valid and ready are high at a clock edge.
// The slots live in one synchronous memory of two banks; the sequencer probes one
// slot per cycle. An insert that triggers a rebuild first walks all CAPACITY source
// slots and probes the destination bank for a free slot for each live key. The
// memory's single read port sets the probe rate. After reset the block sweeps all
// 2 * CAPACITY slots to empty and holds ready low meanwhile. One request is in work
// at a time. The response sits in an output register, so the next request is taken
// while it waits; if the receiver stalls, the following request holds in its final
// step until the output register frees up.
module linear_probe_pointer_set
  import lpps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  lpps_req_if.sink   req_i,
  lpps_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_PROBE,
    S_RB_EXAM,
    S_RB_PLACE,
    S_COMMIT
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              bank_q, bank_d;
  logic [CNT_W-1:0]  live_q, live_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [1:0]        act_q, act_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  tomb_q, tomb_d;
  logic [IDX_W-1:0]  rb_i_q, rb_i_d;
  logic [IDX_W-1:0]  rb_j_q, rb_j_d;
  logic [KEY_W-1:0]  rb_key_q, rb_key_d;
  logic              have_tomb_q, have_tomb_d;
  logic              present_q, present_d;
  logic              empty_ok_q, empty_ok_d;
  logic              refuse_q, refuse_d;
  logic              inv_q, inv_d;
  logic              rebuilt_q, rebuilt_d;

  logic              out_valid_q, out_valid_d;
  logic              out_present_q, out_present_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [CNT_W-1:0]  out_live_q, out_live_d;
  logic              out_rebuilt_q, out_rebuilt_d;

  // Slot memory ports.
  logic [KEY_W-1:0]  mem [2**ADDR_W];
  logic [ADDR_W-1:0] rd_addr;
  logic [KEY_W-1:0]  rd_q;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [KEY_W-1:0]  wd;

  logic [IDX_W-1:0]  rd_hash;
  logic              rd_live;

  assign rd_hash = hash_idx(rd_q);
  assign rd_live = (rd_q != SLOT_EMPTY) && (rd_q != SLOT_TOMB);

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Sequencer next-state logic.
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    bank_d        = bank_q;
    live_d        = live_q;
    used_d        = used_q;
    act_d         = act_q;
    key_d         = key_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    tomb_d        = tomb_q;
    rb_i_d        = rb_i_q;
    rb_j_d        = rb_j_q;
    rb_key_d      = rb_key_q;
    have_tomb_d   = have_tomb_q;
    present_d     = present_q;
    empty_ok_d    = empty_ok_q;
    refuse_d      = refuse_q;
    inv_d         = inv_q;
    rebuilt_d     = rebuilt_q;
    out_valid_d   = out_valid_q;
    out_present_d = out_present_q;
    out_status_d  = out_status_q;
    out_live_d    = out_live_q;
    out_rebuilt_d = out_rebuilt_q;
    rd_addr       = {bank_q, idx_q};
    we            = 1'b0;
    wa            = '0;
    wd            = SLOT_EMPTY;
    req_i.ready   = 1'b0;

    // The receiver drains the output register.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Sweep every slot of both banks to empty after reset.
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      // Take a request and decide between a probe, a rebuild and an invalid-key answer.
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          key_d       = req_i.key;
          act_d       = req_i.action;
          rebuilt_d   = 1'b0;
          refuse_d    = 1'b0;
          inv_d       = 1'b0;
          present_d   = 1'b0;
          have_tomb_d = 1'b0;
          empty_ok_d  = 1'b0;
          if (req_i.key == SLOT_EMPTY || req_i.key == SLOT_TOMB) begin
            inv_d   = 1'b1;
            state_d = S_COMMIT;
          end else if (req_i.action == ACT_INSERT && used_q >= HALF_CAP) begin
            if (live_q > QUARTER_CAP) begin
              refuse_d = 1'b1;
              state_d  = S_START;
            end else begin
              rb_i_d  = '0;
              rd_addr = {bank_q, IDX_W'(0)};
              state_d = S_RB_EXAM;
            end
          end else begin
            state_d = S_START;
          end
        end
      end

      // Issue the read of the key's home slot.
      S_START: begin
        idx_d   = hash_idx(key_q);
        cnt_d   = '0;
        rd_addr = {bank_q, hash_idx(key_q)};
        state_d = S_PROBE;
      end

      // Check one slot per cycle; remember the first tombstone on the path.
      S_PROBE: begin
        if (rd_q == SLOT_EMPTY) begin
          empty_ok_d = 1'b1;
          state_d    = S_COMMIT;
        end else if (rd_q == key_q) begin
          present_d = 1'b1;
          state_d   = S_COMMIT;
        end else begin
          if (rd_q == SLOT_TOMB && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = idx_q;
          end
          if (cnt_q == '1) begin
            state_d = S_COMMIT;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            cnt_d   = cnt_q + IDX_W'(1);
            rd_addr = {bank_q, idx_q + IDX_W'(1)};
          end
        end
      end

      // Rebuild: empty each source slot; a live key moves to the other bank.
      S_RB_EXAM: begin
        we = 1'b1;
        wa = {bank_q, rb_i_q};
        wd = SLOT_EMPTY;
        if (rd_live) begin
          rb_key_d = rd_q;
          rb_j_d   = rd_hash;
          rd_addr  = {~bank_q, rd_hash};
          state_d  = S_RB_PLACE;
        end else if (rb_i_q == '1) begin
          bank_d    = ~bank_q;
          used_d    = live_q;
          rebuilt_d = 1'b1;
          state_d   = S_START;
        end else begin
          rb_i_d  = rb_i_q + IDX_W'(1);
          rd_addr = {bank_q, rb_i_q + IDX_W'(1)};
        end
      end

      // Rebuild: probe the destination bank for an empty slot.
      S_RB_PLACE: begin
        if (rd_q == SLOT_EMPTY) begin
          we = 1'b1;
          wa = {~bank_q, rb_j_q};
          wd = rb_key_q;
          if (rb_i_q == '1) begin
            bank_d    = ~bank_q;
            used_d    = live_q;
            rebuilt_d = 1'b1;
            state_d   = S_START;
          end else begin
            rb_i_d  = rb_i_q + IDX_W'(1);
            rd_addr = {bank_q, rb_i_q + IDX_W'(1)};
            state_d = S_RB_EXAM;
          end
        end else begin
          rb_j_d  = rb_j_q + IDX_W'(1);
          rd_addr = {~bank_q, rb_j_q + IDX_W'(1)};
        end
      end

      // Apply the update and load the response once the output register is free.
      S_COMMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d   = 1'b1;
          out_status_d  = STS_DONE;
          out_present_d = present_q;
          out_rebuilt_d = rebuilt_q;
          out_live_d    = live_q;
          if (inv_q) begin
            out_status_d  = STS_INVALID;
            out_present_d = 1'b0;
            out_rebuilt_d = 1'b0;
          end else begin
            case (act_q)
              ACT_INSERT: begin
                if (refuse_q) begin
                  out_status_d = STS_FULL;
                end else if (present_q) begin
                  out_status_d = STS_DONE;
                end else if (have_tomb_q) begin
                  we         = 1'b1;
                  wa         = {bank_q, tomb_q};
                  wd         = key_q;
                  live_d     = live_q + CNT_W'(1);
                  out_live_d = live_q + CNT_W'(1);
                end else if (empty_ok_q) begin
                  we         = 1'b1;
                  wa         = {bank_q, idx_q};
                  wd         = key_q;
                  live_d     = live_q + CNT_W'(1);
                  used_d     = used_q + CNT_W'(1);
                  out_live_d = live_q + CNT_W'(1);
                end else begin
                  out_status_d = STS_FULL;
                end
              end
              ACT_REMOVE: begin
                if (present_q) begin
                  we = 1'b1;
                  wa = {bank_q, idx_q};
                  wd = SLOT_TOMB;
                  if (live_q != '0) begin
                    live_d     = live_q - CNT_W'(1);
                    out_live_d = live_q - CNT_W'(1);
                  end
                end
              end
              default: begin
                out_status_d = STS_DONE;
              end
            endcase
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, counters and the response valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      bank_q      <= 1'b0;
      live_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      bank_q      <= bank_d;
      live_q      <= live_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    act_q         <= act_d;
    key_q         <= key_d;
    idx_q         <= idx_d;
    cnt_q         <= cnt_d;
    tomb_q        <= tomb_d;
    rb_i_q        <= rb_i_d;
    rb_j_q        <= rb_j_d;
    rb_key_q      <= rb_key_d;
    have_tomb_q   <= have_tomb_d;
    present_q     <= present_d;
    empty_ok_q    <= empty_ok_d;
    refuse_q      <= refuse_d;
    inv_q         <= inv_d;
    rebuilt_q     <= rebuilt_d;
    out_present_q <= out_present_d;
    out_status_q  <= out_status_d;
    out_live_q    <= out_live_d;
    out_rebuilt_q <= out_rebuilt_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.was_present = out_present_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.live_count  = out_live_q;
  assign rsp_o.rebuilt     = out_rebuilt_q;

endmodule

// ----- tb/sv/lpps_tb_if.sv -----
// Testbench-side note: the block's channel interfaces come from the RTL sources.
// This file holds the scoreboard class of the set test; it depends on lpps_pkg.
`timescale 1ns / 1ps
package lpps_tb_pkg;
  import lpps_pkg::*;

  typedef struct packed {
    logic             was_present;
    logic [1:0]       status;
    logic [CNT_W-1:0] live_count;
    logic             rebuilt;
  } set_answer_t;

  // Shadow of the set with its own copy of both banks and the counters.
  class set_scoreboard;
    logic [KEY_W-1:0] slots [2*CAPACITY];
    bit               bank;
    int unsigned      live;
    int unsigned      used;
    set_answer_t      pending [$];
    int               errors;

    function new();
      foreach (slots[i]) slots[i] = SLOT_EMPTY;
      bank   = 0;
      live   = 0;
      used   = 0;
      errors = 0;
    endfunction

    function int unsigned home_slot(logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] p;
      p = (k >> 4) * HASH_MULT;
      return p & (CAPACITY - 1);
    endfunction

    function int unsigned base(bit b);
      return b ? CAPACITY : 0;
    endfunction

    // Returns the slot holding k, or -1 when the probe hits an empty slot or finds no match.
    function int locate(logic [KEY_W-1:0] k);
      int unsigned i;
      i = home_slot(k);
      for (int n = 0; n < CAPACITY; n++) begin
        if (slots[base(bank) + i] == SLOT_EMPTY) return -1;
        if (slots[base(bank) + i] == k) return i;
        i = (i + 1) % CAPACITY;
      end
      return -1;
    endfunction

    // Move live keys into the other bank, dropping tombstones.
    function void purge_tombstones();
      int unsigned src, dst, j;
      src = base(bank);
      dst = base(!bank);
      for (int i = 0; i < CAPACITY; i++) slots[dst + i] = SLOT_EMPTY;
      for (int i = 0; i < CAPACITY; i++) begin
        if (slots[src + i] != SLOT_EMPTY && slots[src + i] != SLOT_TOMB) begin
          j = home_slot(slots[src + i]);
          while (slots[dst + j] != SLOT_EMPTY) j = (j + 1) % CAPACITY;
          slots[dst + j] = slots[src + i];
        end
      end
      for (int i = 0; i < CAPACITY; i++) slots[src + i] = SLOT_EMPTY;
      bank = !bank;
      used = live;
    endfunction

    // Note an accepted request and queue the answer it must produce.
    function void note_request(logic [1:0] act, logic [KEY_W-1:0] k);
      set_answer_t a;
      int          at, tomb;
      int unsigned i;
      bit          found_empty;
      a = '0;
      a.status = STS_DONE;
      if (k == SLOT_EMPTY || k == SLOT_TOMB) begin
        a.status = STS_INVALID;
      end else if (act == ACT_INSERT) begin
        a.was_present = (locate(k) >= 0);
        if ((used + 1) * 2 > CAPACITY) begin
          if (live * 4 > CAPACITY) begin
            a.status = STS_FULL;
          end else begin
            purge_tombstones();
            a.rebuilt = 1'b1;
          end
        end
        if (a.status == STS_DONE && !a.was_present) begin
          i = home_slot(k);
          tomb = -1;
          found_empty = 0;
          for (int n = 0; n < CAPACITY; n++) begin
            if (slots[base(bank) + i] == SLOT_EMPTY) begin
              found_empty = 1;
              break;
            end
            if (slots[base(bank) + i] == SLOT_TOMB && tomb < 0) tomb = i;
            i = (i + 1) % CAPACITY;
          end
          if (tomb >= 0) begin
            slots[base(bank) + tomb] = k;
            live++;
          end else if (found_empty) begin
            slots[base(bank) + i] = k;
            used++;
            live++;
          end else begin
            a.status = STS_FULL;
          end
        end
      end else if (act == ACT_REMOVE) begin
        at = locate(k);
        a.was_present = (at >= 0);
        if (at >= 0) begin
          slots[base(bank) + at] = SLOT_TOMB;
          if (live > 0) live--;
        end
      end else begin
        a.was_present = (locate(k) >= 0);
      end
      a.live_count = live[CNT_W-1:0];
      pending.push_back(a);
    endfunction

    // Compare one response with the oldest queued answer.
    function void check_answer(set_answer_t got);
      set_answer_t exp;
      if (pending.size() == 0) begin
        $error("response with nothing outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.was_present !== exp.was_present) begin
        $error("was_present: expected %0d, actual %0d", exp.was_present, got.was_present);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.live_count !== exp.live_count) begin
        $error("live_count: expected %0d, actual %0d", exp.live_count, got.live_count);
        errors++;
      end
      if (got.rebuilt !== exp.rebuilt) begin
        $error("rebuilt: expected %0d, actual %0d", exp.rebuilt, got.rebuilt);
        errors++;
      end
    endfunction
  endclass
endpackage

// ----- tb/sv/tb_top.sv -----
// Top of the set test: drives requests, stalls responses, checks against the scoreboard.
// Depends on lpps_pkg, the two channel interfaces and lpps_tb_pkg.
`timescale 1ns / 1ps
module tb_top;
  import lpps_pkg::*;
  import lpps_tb_pkg::*;

  localparam int IDLE_LIMIT = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lpps_req_if req_if ();
  lpps_rsp_if rsp_if ();

  linear_probe_pointer_set dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  set_scoreboard sb = new();
  logic [KEY_W-1:0] key_pool [$];
  bit  stim_done = 0;
  bit  rsp_hold = 0;
  int  idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    req_if.valid  = 1'b0;
    req_if.action = ACT_LOOKUP;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Random gap length: mostly short, now and then long.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offer one request and wait until it is accepted. Valid stays high afterwards;
  // the caller drops it before any idle stretch.
  task automatic send_request(logic [1:0] act, logic [KEY_W-1:0] k);
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.key    <= k;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(act, k);
  endtask

  task automatic send_with_gap(logic [1:0] act, logic [KEY_W-1:0] k, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    send_request(act, k);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    k = {$urandom, $urandom};
    if (k <= 1) k = 64'd2;
    return k;
  endfunction

  // Keys reused from the pool so lookups and removes hit.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (key_pool.size() == 0 || $urandom_range(0, 3) == 0) begin
      k = rand_key();
      key_pool.push_back(k);
      if (key_pool.size() > 400) void'(key_pool.pop_front());
      return k;
    end
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // The sender stops offering and waits until every response has come.
  task automatic pause_sender();
    req_if.valid <= 1'b0;
    wait_drained();
  endtask

  // Stimulus: directed corner cases, then fill/empty phases with random content.
  initial begin
    logic [1:0] act;
    int         r;
    @(posedge rst_ni);
    @(posedge clk_i);
    send_request(ACT_LOOKUP, 64'd0);
    send_request(ACT_INSERT, 64'd1);
    send_request(ACT_REMOVE, 64'd0);
    send_request(ACT_INSERT, '1);
    send_request(ACT_INSERT, '1);
    send_request(ACT_LOOKUP, '1);
    send_request(2'd3, '1);
    send_request(ACT_REMOVE, '1);
    send_request(ACT_REMOVE, '1);
    send_request(ACT_INSERT, 64'd2);
    // Keys sharing a home slot force probe chains and tombstone reuse.
    send_request(ACT_INSERT, 64'h10);
    send_request(ACT_INSERT, 64'h10 + 64'd1);
    send_request(ACT_INSERT, 64'h10 + 64'd2);
    send_request(ACT_REMOVE, 64'h11);
    send_request(ACT_INSERT, 64'h1F);
    send_request(ACT_LOOKUP, 64'h12);
    send_request(ACT_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ACT_INSERT, 64'h5555_5555_5555_5555);
    pause_sender();

    // Four phases: random traffic, then a removal sweep, each ending in a sender pause.
    for (int ph = 0; ph < 4; ph++) begin
      // Heavy insert phase reaches the rebuild and table-full paths.
      for (int n = 0; n < 330; n++) begin
        r = $urandom_range(0, 99);
        act = (r < 65) ? ACT_INSERT : (r < 80) ? ACT_REMOVE : (r < 97) ? ACT_LOOKUP : 2'd3;
        if (r == 99) send_with_gap(act, $urandom_range(0, 1), ph != 1);
        else if (act == ACT_INSERT && ($urandom_range(0, 2) != 0))
          send_with_gap(act, rand_key(), ph != 1);
        else send_with_gap(act, pick_key(), ph != 1);
      end
      pause_sender();
      // Remove much of the pool so the next phase sees tombstones.
      foreach (key_pool[i])
        if ($urandom_range(0, 1)) send_with_gap(ACT_REMOVE, key_pool[i], ph[0]);
      pause_sender();
    end
    stim_done = 1;
  end

  // Response side: random stalls, one long hold-off while requests keep coming.
  initial begin
    int g;
    bit held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && sb.pending.size() > 0 && sb.used > 100) begin
        held = 1;
        rsp_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      g = gap_len();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Check every accepted response.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_answer('{rsp_if.was_present, rsp_if.status, rsp_if.live_count,
                        rsp_if.rebuilt});
  end

  // Watchdog on cycles with no accepted request or response.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("linear_probe_pointer_set test failed");
      $finish;
    end
  end

  // Finish once everything has been answered.
  initial begin
    wait (stim_done);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("linear_probe_pointer_set test passed");
    end else begin
      $display("linear_probe_pointer_set test failed");
    end
    $finish;
  end
endmodule
